// ===== hdl/dbc_pkg.sv =====
// DMA burst copy controller: shared types, register offsets and codes.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package dbc_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] reg_offset;
        logic [31:0] write_value;
        logic        response_ok;
    } dbc_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] read_value;
        logic        address_error;
        logic        request_is_write;
        logic [31:0] request_address;
        logic [6:0]  request_length;
        logic        irq_level;
        logic        last;
    } dbc_out_t;

    // results caused by one accepted transfer: one or two
    typedef struct packed {
        dbc_out_t first;
        dbc_out_t second;
        logic     two;
    } dbc_pair_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } dbc_phase_t;

    localparam logic [1:0] KIND_REG_READ  = 2'd0;
    localparam logic [1:0] KIND_REG_WRITE = 2'd1;
    localparam logic [1:0] KIND_MEM_RESP  = 2'd2;

    localparam logic [1:0] RK_REPLY   = 2'd0;
    localparam logic [1:0] RK_REQUEST = 2'd1;
    localparam logic [1:0] RK_DONE    = 2'd2;

    localparam logic [31:0] OFF_SOURCE  = 32'h00;
    localparam logic [31:0] OFF_DEST    = 32'h04;
    localparam logic [31:0] OFF_COUNT   = 32'h08;
    localparam logic [31:0] OFF_CONTROL = 32'h0C;
    localparam logic [31:0] OFF_STATUS  = 32'h10;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_BUSY = 3'd1;
    localparam logic [2:0] ST_DONE = 3'd2;
    localparam logic [2:0] ST_FAIL = 3'd6;

endpackage

// ===== hdl/dbc_front.sv =====
// DMA burst copy controller front end: register file and copy sequencer.
// Decodes each transfer and produces its result pair. Uses dbc_pkg.
`timescale 1ns / 1ps

module dbc_front #(
    parameter int BURST_BYTES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  dbc_pkg::dbc_in_t   in_item,
    output logic               push,
    output dbc_pkg::dbc_pair_t push_pair
);
    import dbc_pkg::*;

    localparam logic [31:0] BURST = 32'(BURST_BYTES);

    logic [31:0] source_reg, source_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] control_reg, control_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] cur_src_reg, cur_src_next;
    logic [31:0] cur_dst_reg, cur_dst_next;
    logic [31:0] left_reg, left_next;
    logic        irq_reg, irq_next;
    dbc_phase_t  phase_reg, phase_next;

    logic [31:0] chunk;
    logic [31:0] left_after;
    logic [31:0] next_chunk;
    logic [31:0] count_chunk;
    logic        start;

    assign chunk       = (left_reg < BURST) ? left_reg : BURST;
    assign left_after  = left_reg - chunk;
    assign next_chunk  = (left_after < BURST) ? left_after : BURST;
    assign count_chunk = (count_reg < BURST) ? count_reg : BURST;
    assign start       = (in_item.kind == KIND_REG_WRITE) &&
                         (in_item.reg_offset == OFF_CONTROL) &&
                         in_item.write_value[0] && (phase_reg == PH_IDLE);

    always_comb begin
        phase_next = phase_reg;
        if (in_accept) begin
            case (in_item.kind)
                KIND_REG_WRITE: begin
                    if (start) begin
                        phase_next = (count_reg == 32'd0) ? PH_IDLE : PH_READ;
                    end
                end
                KIND_MEM_RESP: begin
                    case (phase_reg)
                        PH_READ: begin
                            phase_next = in_item.response_ok ? PH_WRITE : PH_IDLE;
                        end
                        PH_WRITE: begin
                            phase_next = (!in_item.response_ok || left_after == 32'd0) ?
                                         PH_IDLE : PH_READ;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb begin
        source_next  = source_reg;
        dest_next    = dest_reg;
        count_next   = count_reg;
        control_next = control_reg;
        status_next  = status_reg;
        cur_src_next = cur_src_reg;
        cur_dst_next = cur_dst_reg;
        left_next    = left_reg;
        irq_next     = irq_reg;
        push         = 1'b0;
        push_pair    = '0;
        if (in_accept) begin
            case (in_item.kind)
                KIND_REG_READ, KIND_REG_WRITE: begin
                    push = 1'b1;
                    push_pair.first.result_kind = RK_REPLY;
                    push_pair.first.last        = 1'b1;
                    case (in_item.reg_offset)
                        OFF_SOURCE: begin
                            if (in_item.kind == KIND_REG_WRITE) begin
                                source_next = in_item.write_value;
                            end else begin
                                push_pair.first.read_value = source_reg;
                            end
                        end
                        OFF_DEST: begin
                            if (in_item.kind == KIND_REG_WRITE) begin
                                dest_next = in_item.write_value;
                            end else begin
                                push_pair.first.read_value = dest_reg;
                            end
                        end
                        OFF_COUNT: begin
                            if (in_item.kind == KIND_REG_WRITE) begin
                                count_next = in_item.write_value;
                            end else begin
                                push_pair.first.read_value = count_reg;
                            end
                        end
                        OFF_CONTROL: begin
                            if (in_item.kind == KIND_REG_WRITE) begin
                                control_next = in_item.write_value;
                            end else begin
                                push_pair.first.read_value = control_reg;
                            end
                        end
                        OFF_STATUS: begin
                            if (in_item.kind == KIND_REG_WRITE) begin
                                status_next = ST_IDLE;
                                irq_next    = 1'b0;
                            end else begin
                                push_pair.first.read_value = {29'd0, status_reg};
                            end
                        end
                        default: begin
                            push_pair.first.address_error = 1'b1;
                        end
                    endcase
                    push_pair.first.irq_level = irq_next;
                    if (start) begin
                        push_pair.two        = 1'b1;
                        push_pair.first.last = 1'b0;
                        cur_src_next = source_reg;
                        cur_dst_next = dest_reg;
                        left_next    = count_reg;
                        push_pair.second.last = 1'b1;
                        if (count_reg == 32'd0) begin
                            status_next = ST_DONE;
                            irq_next    = irq_next | in_item.write_value[1];
                            push_pair.second.result_kind = RK_DONE;
                        end else begin
                            status_next = ST_BUSY;
                            push_pair.second.result_kind     = RK_REQUEST;
                            push_pair.second.request_address = source_reg;
                            push_pair.second.request_length  = count_chunk[6:0];
                        end
                        push_pair.second.irq_level = irq_next;
                    end
                end
                KIND_MEM_RESP: begin
                    push_pair.first.last = 1'b1;
                    case (phase_reg)
                        PH_READ, PH_WRITE: begin
                            push = 1'b1;
                            if (!in_item.response_ok) begin
                                status_next = ST_FAIL;
                                irq_next    = irq_reg | control_reg[1];
                                push_pair.first.result_kind = RK_DONE;
                            end else if (phase_reg == PH_READ) begin
                                push_pair.first.result_kind      = RK_REQUEST;
                                push_pair.first.request_is_write = 1'b1;
                                push_pair.first.request_address  = cur_dst_reg;
                                push_pair.first.request_length   = chunk[6:0];
                            end else begin
                                cur_src_next = cur_src_reg + chunk;
                                cur_dst_next = cur_dst_reg + chunk;
                                left_next    = left_after;
                                if (left_after == 32'd0) begin
                                    status_next = ST_DONE;
                                    irq_next    = irq_reg | control_reg[1];
                                    push_pair.first.result_kind = RK_DONE;
                                end else begin
                                    push_pair.first.result_kind     = RK_REQUEST;
                                    push_pair.first.request_address = cur_src_reg + chunk;
                                    push_pair.first.request_length  = next_chunk[6:0];
                                end
                            end
                            push_pair.first.irq_level = irq_next;
                        end
                        default: begin
                            push = 1'b0;
                        end
                    endcase
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_reg  <= '0;
            dest_reg    <= '0;
            count_reg   <= '0;
            control_reg <= '0;
            status_reg  <= ST_IDLE;
            cur_src_reg <= '0;
            cur_dst_reg <= '0;
            left_reg    <= '0;
            irq_reg     <= 1'b0;
            phase_reg   <= PH_IDLE;
        end else begin
            source_reg  <= source_next;
            dest_reg    <= dest_next;
            count_reg   <= count_next;
            control_reg <= control_next;
            status_reg  <= status_next;
            cur_src_reg <= cur_src_next;
            cur_dst_reg <= cur_dst_next;
            left_reg    <= left_next;
            irq_reg     <= irq_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

// ===== hdl/dbc_queue.sv =====
// DMA burst copy controller: result queue between front end and back end.
// Holds result pairs in a small register FIFO. Uses dbc_pkg.
`timescale 1ns / 1ps

module dbc_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dbc_pkg::dbc_pair_t push_pair,
    input  logic               pop,
    output dbc_pkg::dbc_pair_t pop_pair,
    output logic               full,
    output logic               empty
);
    import dbc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    dbc_pair_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_pair = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/dbc_back.sv =====
// DMA burst copy controller back end: output register that unpacks pairs.
// Presents the results of each pair one at a time on the m_ channel. Uses dbc_pkg.
`timescale 1ns / 1ps

module dbc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  dbc_pkg::dbc_pair_t pop_pair,
    input  logic               empty,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output dbc_pkg::dbc_out_t  m_payload
);
    import dbc_pkg::*;

    dbc_pair_t pair_reg, pair_next;
    logic      valid_reg, valid_next;
    logic      sel_reg, sel_next;
    logic      take, pair_done;

    assign take      = valid_reg && m_ready;
    assign pair_done = take && (sel_reg || !pair_reg.two);
    assign pop       = (!valid_reg || pair_done) && !empty;
    assign m_valid   = valid_reg;
    assign m_payload = sel_reg ? pair_reg.second : pair_reg.first;

    always_comb begin
        pair_next  = pair_reg;
        valid_next = valid_reg;
        sel_next   = sel_reg;
        if (pop) begin
            pair_next  = pop_pair;
            valid_next = 1'b1;
            sel_next   = 1'b0;
        end else if (pair_done) begin
            valid_next = 1'b0;
            sel_next   = 1'b0;
        end else if (take) begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        pair_reg <= pair_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ===== hdl/dma_burst_copy_controller.sv =====
// DMA burst copy controller top level.
// Instantiates dbc_front, dbc_queue and dbc_back; uses dbc_pkg.
//
// Usage:
//   s_ channel carries register reads, register writes and memory responses.
//   m_ channel returns register replies, memory read/write requests and
//   copy-finished results; last marks the final result of each transfer.
//   A control write that starts a copy gives two results, every other
//   transfer gives one or none (ignored responses and unknown kinds).
// Path: when the m_ side is free, the first result of a transfer goes into
//   the queue at the accepting edge and from there into the output
//   register, which drives m_.
// Throughput: one transfer per cycle while the queue has room; the front
//   end decodes and updates all registers in the accepting cycle. The
//   output register drains one result per cycle while m_ready is high.
// Stall: while m_ready is low results wait in the QUEUE_DEPTH entry queue
//   and in the output register; s_ready drops once the queue is full.
// Reset: all registers read back zero, status idle, interrupt low, queue
//   and output register empty.
`timescale 1ns / 1ps

module dma_burst_copy_controller #(
    parameter int BURST_BYTES = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dbc_pkg::dbc_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output dbc_pkg::dbc_out_t m_payload
);
    import dbc_pkg::*;

    logic      accept;
    logic      push, pop, full, empty;
    dbc_pair_t push_pair, pop_pair;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    dbc_front #(
        .BURST_BYTES(BURST_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_accept(accept),
        .in_item  (s_payload),
        .push     (push),
        .push_pair(push_pair)
    );

    dbc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_pair(push_pair),
        .pop      (pop),
        .pop_pair (pop_pair),
        .full     (full),
        .empty    (empty)
    );

    dbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_pair (pop_pair),
        .empty    (empty),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

endmodule

// ===== hdl/dbc_checker.sv =====
// DMA burst copy controller port checker and its bind to the top level.
// Watches the s_ and m_ channels only. Uses dbc_pkg.
`timescale 1ns / 1ps

module dbc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input dbc_pkg::dbc_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input dbc_pkg::dbc_out_t m_payload
);
    import dbc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("transfer changed while waiting");

    a_addr_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.address_error |->
            m_payload.result_kind == RK_REPLY && m_payload.read_value == 32'd0)
        else $error("address error carries data");

    a_req_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.result_kind != RK_REQUEST |->
            m_payload.request_address == 32'd0 && m_payload.request_length == 7'd0 &&
            !m_payload.request_is_write)
        else $error("request fields on non-request result");

endmodule

bind dma_burst_copy_controller dbc_checker u_dbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_payload(s_payload),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);

// ===== dv/dma_burst_copy_controller_tb.sv =====
// Testbench for dma_burst_copy_controller: directed and random register, start and
// memory-response transfers, with results checked against an in-bench predictor.
// Depends on dbc_pkg and the dma_burst_copy_controller RTL only.
`timescale 1ns / 1ps

module dma_burst_copy_controller_tb;
    import dbc_pkg::*;

    localparam int          BURST       = 64;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 16;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    dbc_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    dbc_out_t m_payload;

    dma_burst_copy_controller #(.BURST_BYTES(BURST)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    dbc_in_t    pending_transfers[$];
    dbc_out_t   expected_results[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         n_pushed       = 0;
    int         n_accepted     = 0;
    int         n_checked      = 0;
    int         n_copies       = 0;
    int         n_fail         = 0;
    int         quiet_cycles   = 0;

    // predicted block state
    logic [31:0] src_q, dst_q, count_q, ctrl_q;
    logic [2:0]  status_q;
    logic [31:0] cur_src_q, cur_dst_q, left_q;
    dbc_phase_t  phase_q;
    logic        irq_q;

    initial begin
        src_q     = '0;
        dst_q     = '0;
        count_q   = '0;
        ctrl_q    = '0;
        status_q  = ST_IDLE;
        cur_src_q = '0;
        cur_dst_q = '0;
        left_q    = '0;
        phase_q   = PH_IDLE;
        irq_q     = 1'b0;
    end

    function automatic dbc_out_t make_result(logic [1:0] rk, logic [31:0] rv, logic ae,
                                             logic wr, logic [31:0] addr, logic [6:0] len,
                                             logic lst);
        dbc_out_t r;
        r.result_kind      = rk;
        r.read_value       = rv;
        r.address_error    = ae;
        r.request_is_write = wr;
        r.request_address  = addr;
        r.request_length   = len;
        r.irq_level        = irq_q;
        r.last             = lst;
        return r;
    endfunction

    function automatic logic [31:0] chunk_bytes();
        return (left_q < BURST) ? left_q : BURST;
    endfunction

    task automatic conclude_copy(logic [2:0] st);
        status_q = st;
        phase_q  = PH_IDLE;
        if (ctrl_q[1]) begin
            irq_q = 1'b1;
        end
        expected_results.push_back(make_result(RK_DONE, '0, 1'b0, 1'b0, '0, '0, 1'b1));
    endtask

    task automatic issue_request(logic wr);
        logic [31:0] c;
        c = chunk_bytes();
        expected_results.push_back(make_result(RK_REQUEST, '0, 1'b0, wr,
                                               wr ? cur_dst_q : cur_src_q, c[6:0], 1'b1));
    endtask

    task automatic predict_transfer(dbc_in_t t);
        logic        wr;
        logic        go;
        logic        decoded;
        logic [31:0] rv;
        logic [31:0] c;
        wr      = (t.kind == KIND_REG_WRITE);
        go      = 1'b0;
        decoded = 1'b1;
        rv      = '0;
        if (t.kind == KIND_REG_READ || t.kind == KIND_REG_WRITE) begin
            case (t.reg_offset)
                OFF_SOURCE: begin
                    if (wr) src_q = t.write_value; else rv = src_q;
                end
                OFF_DEST: begin
                    if (wr) dst_q = t.write_value; else rv = dst_q;
                end
                OFF_COUNT: begin
                    if (wr) count_q = t.write_value; else rv = count_q;
                end
                OFF_CONTROL: begin
                    if (wr) begin
                        ctrl_q = t.write_value;
                        go     = t.write_value[0] && (phase_q == PH_IDLE);
                    end else begin
                        rv = ctrl_q;
                    end
                end
                OFF_STATUS: begin
                    if (wr) begin
                        status_q = ST_IDLE;
                        irq_q    = 1'b0;
                    end else begin
                        rv = 32'(status_q);
                    end
                end
                default: decoded = 1'b0;
            endcase
            if (!decoded) begin
                expected_results.push_back(make_result(RK_REPLY, '0, 1'b1, 1'b0, '0, '0, 1'b1));
            end else begin
                expected_results.push_back(make_result(RK_REPLY, rv, 1'b0, 1'b0, '0, '0, !go));
                if (go) begin
                    n_copies++;
                    cur_src_q = src_q;
                    cur_dst_q = dst_q;
                    left_q    = count_q;
                    status_q  = ST_BUSY;
                    if (left_q == 0) begin
                        conclude_copy(ST_DONE);
                    end else begin
                        phase_q = PH_READ;
                        issue_request(1'b0);
                    end
                end
            end
        end else if (t.kind == KIND_MEM_RESP && phase_q != PH_IDLE) begin
            if (!t.response_ok) begin
                conclude_copy(ST_FAIL);
            end else if (phase_q == PH_READ) begin
                phase_q = PH_WRITE;
                issue_request(1'b1);
            end else begin
                c          = chunk_bytes();
                cur_src_q += c;
                cur_dst_q += c;
                left_q    -= c;
                if (left_q == 0) begin
                    conclude_copy(ST_DONE);
                end else begin
                    phase_q = PH_READ;
                    issue_request(1'b0);
                end
            end
        end
    endtask

    // driver: hold the payload until the transfer, then advance or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_transfer(s_payload);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_transfers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_payload <= pending_transfers.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            n_fail++;
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        dbc_out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %h", m_payload);
                n_fail++;
            end else begin
                w = expected_results.pop_front();
                check_field("result_kind", 32'(w.result_kind), 32'(m_payload.result_kind));
                check_field("read_value", w.read_value, m_payload.read_value);
                check_field("address_error", 32'(w.address_error),
                            32'(m_payload.address_error));
                check_field("request_is_write", 32'(w.request_is_write),
                            32'(m_payload.request_is_write));
                check_field("request_address", w.request_address, m_payload.request_address);
                check_field("request_length", 32'(w.request_length),
                            32'(m_payload.request_length));
                check_field("irq_level", 32'(w.irq_level), 32'(m_payload.irq_level));
                check_field("last", 32'(w.last), 32'(m_payload.last));
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
        end
        $display("Watchdog: %0d cycles without a transfer", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic push_item(logic [1:0] k, logic [31:0] off, logic [31:0] val, logic ok);
        dbc_in_t t;
        t.kind        = k;
        t.reg_offset  = off;
        t.write_value = val;
        t.response_ok = ok;
        pending_transfers.push_back(t);
        n_pushed++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return OFF_SOURCE;
            1: return OFF_DEST;
            2: return OFF_COUNT;
            3: return OFF_CONTROL;
            default: return OFF_STATUS;
        endcase
    endfunction

    task automatic push_noise(bit busy);
        logic [31:0] v;
        logic [31:0] off;
        v = $urandom();
        case ($urandom_range(0, 6))
            0: push_item(KIND_REG_READ, pick_offset(), v, 1'($urandom_range(0, 1)));
            1: begin
                case ($urandom_range(0, 2))
                    0: off = OFF_SOURCE;
                    1: off = OFF_DEST;
                    default: off = OFF_COUNT;
                endcase
                push_item(KIND_REG_WRITE, off, v, 1'($urandom_range(0, 1)));
            end
            2: push_item(KIND_REG_WRITE, OFF_STATUS, v, 1'($urandom_range(0, 1)));
            3: begin
                if (!busy) v[0] = 1'b0;
                push_item(KIND_REG_WRITE, OFF_CONTROL, v, 1'($urandom_range(0, 1)));
            end
            4: begin
                if ($urandom_range(0, 1)) begin
                    off = $urandom();
                end else begin
                    off = pick_offset() + $urandom_range(1, 3);
                end
                push_item($urandom_range(0, 1) ? KIND_REG_WRITE : KIND_REG_READ, off, v,
                          1'($urandom_range(0, 1)));
            end
            5: push_item(KIND_UNUSED, $urandom(), v, 1'($urandom_range(0, 1)));
            default: begin
                if (busy) begin
                    push_item(KIND_REG_READ, pick_offset(), v, 1'($urandom_range(0, 1)));
                end else begin
                    push_item(KIND_MEM_RESP, $urandom(), v, 1'($urandom_range(0, 1)));
                end
            end
        endcase
    endtask

    // one programmed copy: set up, start, then answer its requests up to an injected failure
    task automatic push_copy();
        logic [31:0] cnt;
        logic [31:0] ctrl;
        longint      chunks;
        longint      resp_n;
        longint      fail_at;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 10)      cnt = 0;
        else if (r < 25) cnt = $urandom_range(1, BURST);
        else if (r < 40) cnt = BURST * $urandom_range(1, 4);
        else if (r < 92) cnt = $urandom_range(1, 400);
        else             cnt = $urandom();
        if ($urandom_range(0, 99) < 80) push_item(KIND_REG_WRITE, OFF_SOURCE, $urandom(), 1'b1);
        if ($urandom_range(0, 99) < 80) push_item(KIND_REG_WRITE, OFF_DEST, $urandom(), 1'b0);
        push_item(KIND_REG_WRITE, OFF_COUNT, cnt, 1'($urandom_range(0, 1)));
        ctrl    = $urandom();
        ctrl[0] = 1'b1;
        push_item(KIND_REG_WRITE, OFF_CONTROL, ctrl, 1'($urandom_range(0, 1)));
        chunks  = (longint'(cnt) + BURST - 1) / BURST;
        resp_n  = 2 * chunks;
        fail_at = -1;
        if (chunks > 12) begin
            fail_at = longint'($urandom_range(0, 23));
        end else if (resp_n > 0 && $urandom_range(0, 99) < 15) begin
            fail_at = longint'($urandom_range(0, int'(resp_n) - 1));
        end
        for (longint i = 0; i < resp_n; i++) begin
            if ($urandom_range(0, 99) < 10) push_noise(1'b1);
            push_item(KIND_MEM_RESP, $urandom(), $urandom(), i != fail_at);
            if (i == fail_at) break;
        end
        if ($urandom_range(0, 99) < 25) push_noise(1'b0);
    endtask

    initial begin
        int target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        push_item(KIND_REG_READ, OFF_STATUS, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_REG_READ, OFF_SOURCE, 32'h0, 1'b0);
        push_item(KIND_REG_WRITE, OFF_SOURCE, 32'hFFFF_FFC0, 1'b0);
        push_item(KIND_REG_WRITE, OFF_DEST, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_REG_WRITE, OFF_COUNT, 32'd80, 1'b0);
        push_item(KIND_REG_WRITE, OFF_CONTROL, 32'h3, 1'b0);
        // start while busy, then count change that the snapshot must ignore
        push_item(KIND_REG_WRITE, OFF_CONTROL, 32'h1, 1'b1);
        push_item(KIND_REG_WRITE, OFF_COUNT, 32'hFFFF_FFFF, 1'b0);
        push_item(KIND_REG_READ, OFF_STATUS, 32'h0, 1'b0);
        repeat (4) push_item(KIND_MEM_RESP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_REG_READ, OFF_STATUS, 32'h0, 1'b1);
        push_item(KIND_MEM_RESP, 32'h0, 32'h0, 1'b1);
        push_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_REG_READ, 32'h14, 32'h0, 1'b0);
        push_item(KIND_REG_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(KIND_REG_WRITE, OFF_COUNT, 32'h0, 1'b1);
        push_item(KIND_REG_WRITE, OFF_CONTROL, 32'hFFFF_FFFF, 1'b0);
        push_item(KIND_REG_READ, OFF_CONTROL, 32'h0, 1'b0);
        push_item(KIND_REG_WRITE, OFF_STATUS, 32'h0, 1'b0);
        push_item(KIND_REG_WRITE, OFF_COUNT, 32'h1, 1'b1);
        push_item(KIND_REG_WRITE, OFF_CONTROL, 32'h3, 1'b1);
        push_item(KIND_MEM_RESP, 32'h0, 32'h0, 1'b0);
        push_item(KIND_REG_READ, OFF_STATUS, 32'h0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            target = n_pushed + 250;
            while (n_pushed < target) push_copy();
            // hold off the sender until every result of the phase is back
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            n_fail++;
        end
        $display("Covered %0d transfers in and %0d results out, %0d copies started,",
                 n_accepted, n_checked, n_copies);
        $display("over runs with no idling, sender gaps, receiver stalls and both together.");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
